FILE: src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  `ASSERT_CLKD(label, (trig) |=> (cons), msg)

`endif

FILE: src/esls_pkg.sv
// Types and constants of the escape stripping line splitter.
`default_nettype none

package esls_pkg;

  // Default line buffer capacity downstream
  localparam int unsigned DefLineCapacity = 256;

  // Event queue depth; two events per item plus one in flight
  localparam int unsigned EvqDepth = 3;

  // Byte codes
  localparam logic [7:0] ChNul      = 8'h00;
  localparam logic [7:0] ChBel      = 8'h07;
  localparam logic [7:0] ChBs       = 8'h08;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChEsc      = 8'h1B;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChSt       = 8'h9C;
  localparam logic [7:0] CsiFinalLo = 8'h40;
  localparam logic [7:0] CsiFinalHi = 8'h7E;

  // Command codes
  localparam logic CmdByte  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Event kinds
  localparam logic EvChar = 1'b0;
  localparam logic EvEnd  = 1'b1;

  // Escape parser state
  typedef enum logic [3:0] {
    ModePlain    = 4'b0001,
    ModeAfterEsc = 4'b0010,
    ModeCsi      = 4'b0100,
    ModeOsc      = 4'b1000
  } mode_e;

  // One output event
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } ev_t;

  // Events produced by one item, handed to the queue
  typedef struct packed {
    logic [1:0] cnt;
    ev_t        ev0;
    ev_t        ev1;
  } evpush_t;

endpackage

`default_nettype wire

FILE: src/esls_core.sv
// Input register, escape parser, line state and per-item event decode.
`default_nettype none

module esls_core import esls_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = DefLineCapacity
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       command_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [1:0] room_i,
  output evpush_t         push_o
);

  localparam int unsigned LenW = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_CAPACITY - 1);

  // Input register
  logic       vld_q, vld_d;
  logic       cmd_q;
  logic [7:0] byte_q;

  // Line state
  mode_e           mode_q, mode_d;
  logic            crp_q, crp_d;
  logic [LenW-1:0] len_q, len_d;

  evpush_t push;
  logic    consume;

  // Decode of the held item
  always_comb begin
    push     = '0;
    mode_d   = mode_q;
    crp_d    = crp_q;
    len_d    = len_q;
    push.ev0 = '{kind: EvEnd, ch: 8'h00, last: 1'b1};
    push.ev1 = '{kind: EvChar, ch: byte_q, last: 1'b1};
    if (cmd_q == CmdFlush) begin
      if (len_q != '0) begin
        push.cnt = 2'd1;
        len_d    = '0;
      end
      crp_d = 1'b0;
    end else begin
      unique case (mode_q)
        ModeAfterEsc: begin
          if (byte_q == ChLBracket) mode_d = ModeCsi;
          else if (byte_q == ChRBracket) mode_d = ModeOsc;
          else mode_d = ModePlain;
        end
        ModeCsi: begin
          if (byte_q >= CsiFinalLo && byte_q <= CsiFinalHi) mode_d = ModePlain;
        end
        ModeOsc: begin
          if (byte_q == ChBel || byte_q == ChSt) mode_d = ModePlain;
          else if (byte_q == ChEsc) mode_d = ModeAfterEsc;
        end
        ModePlain: begin
          if (byte_q == ChEsc) begin
            mode_d = ModeAfterEsc;
          end else if (byte_q == ChCr) begin
            if (len_q != '0) begin
              push.cnt = 2'd1;
              len_d    = '0;
            end
            crp_d = 1'b1;
          end else if (byte_q == ChLf) begin
            // CR-LF on an empty line gives no second end
            if (!(crp_q && len_q == '0)) begin
              push.cnt = 2'd1;
              len_d    = '0;
            end
            crp_d = 1'b0;
          end else begin
            crp_d = 1'b0;
            if (byte_q != ChBs && byte_q != ChNul) begin
              if (len_q >= LenMax) begin
                // full line: end first, then the character
                push.ev0.last = 1'b0;
                push.cnt      = 2'd2;
                len_d         = LenW'(1);
              end else begin
                push.ev0 = push.ev1;
                push.cnt = 2'd1;
                len_d    = len_q + LenW'(1);
              end
            end
          end
        end
        default: mode_d = ModePlain;
      endcase
    end
  end

  // Take the item once the queue has room for all its events
  assign consume    = vld_q && (push.cnt <= room_i);
  assign in_ready_o = !vld_q || consume;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_comb begin
    push_o = push;
    if (!consume) push_o.cnt = 2'd0;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      mode_q <= ModePlain;
      crp_q  <= 1'b0;
      len_q  <= '0;
    end else begin
      vld_q <= vld_d;
      if (consume) begin
        mode_q <= mode_d;
        crp_q  <= crp_d;
        len_q  <= len_d;
      end
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      byte_q <= byte_value_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/esls_evq.sv
// Small event queue: takes up to two events a cycle, gives one.
`default_nettype none

module esls_evq import esls_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire evpush_t    push_i,
  output logic [1:0]      room_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            event_kind_o,
  output logic [7:0]      char_value_o,
  output logic            last_of_run_o
);

  localparam int unsigned CntW = $clog2(EvqDepth + 1);

  ev_t            q_q [EvqDepth];
  ev_t            q_d [EvqDepth];
  logic [CntW-1:0] cnt_q, cnt_d, base;
  logic            pop;

  assign pop  = out_valid_o && out_ready_i;
  assign base = cnt_q - CntW'(pop);

  // Shift out the head, then place new events behind what remains
  always_comb begin
    for (int i = 0; i < EvqDepth; i++) begin
      if (pop && i < EvqDepth - 1) q_d[i] = q_q[i+1];
      else q_d[i] = q_q[i];
      if (push_i.cnt != 2'd0 && base == CntW'(i)) q_d[i] = push_i.ev0;
      if (push_i.cnt == 2'd2 && base + CntW'(1) == CntW'(i)) q_d[i] = push_i.ev1;
    end
    cnt_d = base + CntW'(push_i.cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign room_o        = 2'(CntW'(EvqDepth) - cnt_q);
  assign out_valid_o   = cnt_q != '0;
  assign event_kind_o  = q_q[0].kind;
  assign char_value_o  = q_q[0].ch;
  assign last_of_run_o = q_q[0].last;

endmodule

`default_nettype wire

FILE: src/escape_stripping_line_splitter.sv
// Top level of the escape stripping line splitter.
//
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   command_i, byte_value_i
//  out      out_valid_o / out_ready_i event_kind_o, char_value_o, last_of_run_o
//
// One item a cycle is taken while the event queue has room for its events; an
// item waits in the input register until the queue takes its events.
// A full line yields two events for one item; the single output port, while
// out_ready_i is high, sends one event a cycle; a three-entry queue absorbs it.
// Input ready depends only on registered state, not on out_ready_i.
// Reset clears the parser, the pending CR, the line length and the queue.
`default_nettype none

module escape_stripping_line_splitter import esls_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = DefLineCapacity
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       command_i,
  input  wire logic [7:0] byte_value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            event_kind_o,
  output logic [7:0]      char_value_o,
  output logic            last_of_run_o
);

  evpush_t    push;
  logic [1:0] room;

  // Parser and line state
  esls_core #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_core (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .byte_value_i,
    .room_i (room),
    .push_o (push)
  );

  // Output event queue
  esls_evq u_evq (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .room_o (room),
    .out_valid_o,
    .out_ready_i,
    .event_kind_o,
    .char_value_o,
    .last_of_run_o
  );

endmodule

`default_nettype wire

FILE: src/esls_checker.sv
// Port-level checker for the escape stripping line splitter, with its bind.
`default_nettype none
`include "assert_macros.svh"

module esls_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       event_kind_o,
  input wire logic [7:0] char_value_o,
  input wire logic       last_of_run_o
);

  logic       out_end;
  logic       out_char;
  logic       out_brk;
  logic       out_stall;
  logic [9:0] out_bits;

  assign out_end   = out_valid_o && event_kind_o;
  assign out_char  = out_valid_o && !event_kind_o;
  assign out_brk   = out_end && out_ready_i && !last_of_run_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_bits  = {event_kind_o, char_value_o, last_of_run_o};

  // Input ready is always driven out of reset
  `ASSERT_CLKD(a_ready_known, !$isunknown(in_ready_o), "input ready unknown")

  // End events carry no character
  `ASSERT_CLKD(a_end_char_zero, out_end |-> (char_value_o == 8'h00), "end event with char")

  // A character is always the final event of its item
  `ASSERT_CLKD(a_char_is_last, out_char |-> last_of_run_o, "char event without last")

  // A line break inside a run is followed right away by its character
  `ASSERT_NEXT(a_break_then_char, out_brk, out_char && last_of_run_o, "break not followed by char")

  // Stalled output holds
  `ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_bits), "stalled output changed")

endmodule

bind escape_stripping_line_splitter esls_checker u_esls_checker (
  .clk_i,
  .rst_ni,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .event_kind_o,
  .char_value_o,
  .last_of_run_o
);

`default_nettype wire
